// ===== sv/nvle_pkg.sv =====
`default_nettype none

package nvle_pkg;

    // note length in samples
    localparam int NOTE_SAMPLES = 44100;
    localparam logic [15:0] NOTE_LAST_INDEX = 16'(NOTE_SAMPLES - 1);

    // register map, word index; the spare slots are unmapped
    typedef enum logic [2:0] {
        REG_TEXTURE_GAIN,
        REG_FILTER_ALPHA,
        REG_ATTACK_END,
        REG_DECAY_END,
        REG_RELEASE_END,
        REG_SUSTAIN_LEVEL,
        REG_SPARE_A,
        REG_SPARE_B
    } t_reg_sel;

    // serial multiplier: 17 x 17 unsigned, one multiplier bit per cycle
    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;

    // serial divider: 32-bit operands, 17 quotient bits, one bit per cycle
    localparam int DIV_W  = 32;
    localparam int QUOT_W = 17;

    // step counter width shared by both serial units
    localparam int STEP_W = $clog2((MUL_W > QUOT_W) ? MUL_W : QUOT_W);
    localparam logic [STEP_W-1:0] MUL_STEP_LAST = STEP_W'(MUL_W - 1);
    localparam logic [STEP_W-1:0] DIV_STEP_LAST = STEP_W'(QUOT_W - 1);

endpackage

`default_nettype wire

// ===== sv/nvle_smul.sv =====
`default_nettype none

module nvle_smul
    import nvle_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [MUL_W-1:0]  i_mcand,
    input  wire logic [MUL_W-1:0]  i_mplier,
    output logic                   o_done,
    output logic [PROD_W-1:0]      o_product
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [MUL_W-1:0]  r_mcand;
    logic [MUL_W-1:0]  r_hi;
    logic [MUL_W-1:0]  r_lo;
    logic [MUL_W:0]    step_sum;

    // add the multiplicand when the current multiplier bit is set
    assign step_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : {(MUL_W + 1){1'b0}});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_STEP_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift-add datapath, product bits shift in from the top
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_hi    <= '0;
            r_lo    <= i_mplier;
        end else if (r_busy) begin
            r_hi <= step_sum[MUL_W:1];
            r_lo <= {step_sum[0], r_lo[MUL_W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule

`default_nettype wire

// ===== sv/nvle_sdiv.sv =====
`default_nettype none

module nvle_sdiv
    import nvle_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIV_W-1:0]  i_num,
    input  wire logic [DIV_W-1:0]  i_den,
    output logic                   o_done,
    output logic [QUOT_W-1:0]      o_quot
);

    // numerator must not exceed the denominator; the quotient is then
    // floor(num * 2^(QUOT_W-1) / den)

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W:0]    r_rem;
    logic [DIV_W-1:0]  r_den;
    logic [QUOT_W-1:0] r_quot;
    logic              fits;
    logic [DIV_W:0]    rem_next;

    // restoring step: compare, subtract, shift
    assign fits     = (r_rem >= {1'b0, r_den});
    assign rem_next = fits ? (r_rem - {1'b0, r_den}) : r_rem;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_STEP_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= {rem_next[DIV_W-1:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== sv/noise_voice_lowpass_envelope_unit.sv =====
// Seven bit-serial steps per sample (gain, filter, two squares, ratio divide,
// envelope scale, output scale) on one shared multiplier and one divider; the
// first sample of a note skips the filter. A new noise word is taken only in
// idle, after the last result word has gone to the output register, which
// waits while the output word is held downstream.
// Synchronous active-low reset restores register defaults, clears count and previous sample.
`default_nettype none

module noise_voice_lowpass_envelope_unit
    import nvle_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // stream in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,    // [13:0] noise_value
    // stream out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,    // [15:0] sample_out
    output logic             m_tlast,    // note_last
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [16:0] ENV_ONE = 17'h10000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAIN,
        ST_FILT,
        ST_KSQ,
        ST_LSQ,
        ST_DIV,
        ST_ENV,
        ST_OUT,
        ST_LOAD
    } t_state;

    typedef enum logic [1:0] {
        SEG_ATT,
        SEG_DEC,
        SEG_REL,
        SEG_OFF
    } t_seg;

    // configuration
    logic [15:0] r_gain;
    logic [15:0] r_alpha;
    logic [15:0] r_attack;
    logic [15:0] r_decay;
    logic [15:0] r_release;
    logic [15:0] r_sustain;

    // sequencer and datapath
    t_state      r_state;
    logic        r_mul_start;
    logic        r_div_start;
    logic [13:0] r_noise;
    t_seg        r_seg;
    logic [15:0] r_k;
    logic [15:0] r_len;
    logic [15:0] r_x;
    logic [31:0] r_ksq;
    logic [31:0] r_lsq;
    logic [16:0] r_quot;
    logic [16:0] r_env;
    logic [15:0] r_y;
    logic        r_last;
    logic [15:0] r_index;
    logic [15:0] r_prev;
    logic        r_out_valid;
    logic [15:0] r_out_data;
    logic        r_out_last;

    logic                  cfg_wr;
    logic [2:0]            cfg_sel;
    t_seg                  seg_c;
    logic [15:0]           k_c;
    logic [15:0]           len_c;
    logic [MUL_W-1:0]      mul_mcand;
    logic [MUL_W-1:0]      mul_mplier;
    logic                  mul_done;
    logic [PROD_W-1:0]     mul_prod;
    logic                  div_done;
    logic [QUOT_W-1:0]     div_quot;
    logic                  noise_neg;
    logic [13:0]           noise_mag;
    logic [15:0]           gain_mag;
    logic [15:0]           x_gain;
    logic [16:0]           diff;
    logic                  diff_neg;
    logic [16:0]           diff_mag;
    logic                  x_neg;
    logic [16:0]           x_mag;
    logic [35:0]           acc_base;
    logic [35:0]           acc_prod;
    logic [35:0]           acc;
    logic [19:0]           filt_t;
    logic [15:0]           x_filt;
    logic [16:0]           sus_bar;
    logic [16:0]           env_c;
    logic [17:0]           out_mag;
    logic [15:0]           y_c;
    logic                  slot_free;

    assign cfg_sel = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= 16'h0000;
            r_alpha   <= 16'hFFFF;
            r_attack  <= 16'h0000;
            r_decay   <= 16'h0000;
            r_release <= 16'h0000;
            r_sustain <= 16'h0000;
        end else if (cfg_wr) begin
            case (cfg_sel)
                REG_TEXTURE_GAIN:  r_gain    <= pwdata[15:0];
                REG_FILTER_ALPHA:  r_alpha   <= pwdata[15:0];
                REG_ATTACK_END:    r_attack  <= pwdata[15:0];
                REG_DECAY_END:     r_decay   <= pwdata[15:0];
                REG_RELEASE_END:   r_release <= pwdata[15:0];
                REG_SUSTAIN_LEVEL: r_sustain <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (cfg_sel)
            REG_TEXTURE_GAIN:  prdata = {16'h0000, r_gain};
            REG_FILTER_ALPHA:  prdata = {16'h0000, r_alpha};
            REG_ATTACK_END:    prdata = {16'h0000, r_attack};
            REG_DECAY_END:     prdata = {16'h0000, r_decay};
            REG_RELEASE_END:   prdata = {16'h0000, r_release};
            REG_SUSTAIN_LEVEL: prdata = {16'h0000, r_sustain};
            default:           prdata = 32'h0000_0000;
        endcase
    end

    // envelope segment, curve position and curve length for this sample
    always_comb begin
        seg_c = SEG_OFF;
        k_c   = 16'h0000;
        len_c = 16'h0000;
        if (r_index < r_attack) begin
            seg_c = SEG_ATT;
            k_c   = r_attack - r_index;
            len_c = r_attack;
        end else if (r_index < r_decay) begin
            seg_c = SEG_DEC;
            k_c   = 16'(({1'b0, r_decay} - {1'b0, r_index}) + {1'b0, r_attack});
            len_c = r_decay;
        end else if (r_index < r_release) begin
            seg_c = SEG_REL;
            k_c   = 16'(({1'b0, r_release} - {1'b0, r_index}) + {1'b0, r_decay});
            len_c = r_release;
        end
    end

    // sign and magnitude of the operands
    assign noise_neg = r_noise[13];
    assign noise_mag = noise_neg ? 14'(~r_noise + 14'd1) : r_noise;
    assign diff      = {r_x[15], r_x} - {r_prev[15], r_prev};
    assign diff_neg  = diff[16];
    assign diff_mag  = diff_neg ? 17'(~diff + 17'd1) : diff;
    assign x_neg     = r_x[15];
    assign x_mag     = x_neg ? 17'(~{r_x[15], r_x} + 17'd1) : {1'b0, r_x};
    assign sus_bar   = ENV_ONE - {1'b0, r_sustain};

    // shared multiplier operands
    always_comb begin
        case (r_state)
            ST_GAIN: begin
                mul_mcand  = {1'b0, r_gain};
                mul_mplier = {3'b000, noise_mag};
            end
            ST_FILT: begin
                mul_mcand  = {1'b0, r_alpha};
                mul_mplier = diff_mag;
            end
            ST_KSQ: begin
                mul_mcand  = {1'b0, r_k};
                mul_mplier = {1'b0, r_k};
            end
            ST_LSQ: begin
                mul_mcand  = {1'b0, r_len};
                mul_mplier = {1'b0, r_len};
            end
            ST_ENV: begin
                mul_mcand  = (r_seg == SEG_DEC) ? sus_bar : {1'b0, r_sustain};
                mul_mplier = r_quot;
            end
            ST_OUT: begin
                mul_mcand  = x_mag;
                mul_mplier = r_env;
            end
            default: begin
                mul_mcand  = '0;
                mul_mplier = '0;
            end
        endcase
    end

    // scaled noise, truncated toward zero; always within 14 bits
    assign gain_mag = mul_prod[31:16];
    assign x_gain   = noise_neg ? 16'(~gain_mag + 16'd1) : gain_mag;

    // low-pass: alpha*(x - prev) + prev*65536, truncated toward zero
    assign acc_base = {{4{r_prev[15]}}, r_prev, 16'h0000};
    assign acc_prod = {2'b00, mul_prod};
    assign acc      = diff_neg ? (acc_base - acc_prod) : (acc_base + acc_prod);
    assign filt_t   = acc[35:16] + {19'd0, (acc[35] && (acc[15:0] != 16'h0000))};

    always_comb begin
        if ($signed(filt_t) > 20'sd32767) begin
            x_filt = 16'h7FFF;
        end else if ($signed(filt_t) < -20'sd32768) begin
            x_filt = 16'h8000;
        end else begin
            x_filt = filt_t[15:0];
        end
    end

    // envelope value from the curve ratio
    always_comb begin
        case (r_seg)
            SEG_ATT: env_c = ENV_ONE - r_quot;
            SEG_DEC: env_c = {1'b0, r_sustain} + mul_prod[32:16];
            SEG_REL: env_c = mul_prod[32:16];
            default: env_c = 17'd0;
        endcase
    end

    // enveloped sample, truncated toward zero and saturated
    assign out_mag = mul_prod[33:16];

    always_comb begin
        if (!x_neg) begin
            y_c = (out_mag > 18'd32767) ? 16'h7FFF : out_mag[15:0];
        end else begin
            y_c = (out_mag > 18'd32768) ? 16'h8000 : 16'(~out_mag[15:0] + 16'd1);
        end
    end

    assign slot_free = !r_out_valid || m_tready;

    // sequencer, datapath registers and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            r_index     <= 16'h0000;
            r_prev      <= 16'h0000;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            if (r_out_valid && m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        r_noise     <= s_tdata[13:0];
                        r_seg       <= seg_c;
                        r_k         <= k_c;
                        r_len       <= len_c;
                        r_mul_start <= 1'b1;
                        r_state     <= ST_GAIN;
                    end
                end
                ST_GAIN: begin
                    if (mul_done) begin
                        r_x         <= x_gain;
                        r_mul_start <= 1'b1;
                        // first sample of a note bypasses the filter
                        r_state     <= (r_index != 16'h0000) ? ST_FILT : ST_KSQ;
                    end
                end
                ST_FILT: begin
                    if (mul_done) begin
                        r_x         <= x_filt;
                        r_mul_start <= 1'b1;
                        r_state     <= ST_KSQ;
                    end
                end
                ST_KSQ: begin
                    if (mul_done) begin
                        r_ksq       <= mul_prod[31:0];
                        r_mul_start <= 1'b1;
                        r_state     <= ST_LSQ;
                    end
                end
                ST_LSQ: begin
                    if (mul_done) begin
                        r_lsq       <= mul_prod[31:0];
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_quot      <= div_quot;
                        r_mul_start <= 1'b1;
                        r_state     <= ST_ENV;
                    end
                end
                ST_ENV: begin
                    if (mul_done) begin
                        r_env       <= env_c;
                        r_mul_start <= 1'b1;
                        r_state     <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (mul_done) begin
                        r_y     <= y_c;
                        r_last  <= (r_index >= NOTE_LAST_INDEX);
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_y;
                        r_out_last  <= r_last;
                        r_index     <= r_last ? 16'h0000 : (r_index + 16'd1);
                        r_prev      <= r_last ? 16'h0000 : r_y;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    nvle_smul u_smul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mul_start),
        .i_mcand   (mul_mcand),
        .i_mplier  (mul_mplier),
        .o_done    (mul_done),
        .o_product (mul_prod)
    );

    nvle_sdiv u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_ksq),
        .i_den   (r_lsq),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign s_tready = (r_state == ST_IDLE);
    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;
    assign m_tlast  = r_out_last;

endmodule

`default_nettype wire

// ===== tb/sv/noise_voice_lowpass_envelope_unit_tb.sv =====
`timescale 1ns / 100ps

module noise_voice_lowpass_envelope_unit_tb;
    import nvle_pkg::*;

    localparam int TOTAL_WORDS    = 1550;
    localparam int CALM_WORDS     = 200;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int PRINT_CAP      = 100;
    localparam int NUM_ROWS       = 35;

    typedef enum logic {ROW_WRITE, ROW_NOISE} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        t_reg_sel    sel;
        logic [15:0] value;
        logic        fixed;
        logic [15:0] want;
    } t_script_row;

    typedef struct packed {
        logic [15:0] sample;
        logic        last;
    } t_voice_out;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // [13:0] noise_value, [15:14] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [15:0] sample_out
    logic        m_tlast;           // note_last
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    noise_voice_lowpass_envelope_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // register copies and voice state of the predictor
    logic [15:0] reg_shadow [6];
    logic [15:0] voice_index = '0;
    longint      voice_prev  = 0;

    t_voice_out  pending_samples [$];
    t_voice_out  head_sample;

    int  words_sent      = 0;
    int  samples_seen    = 0;
    int  mismatch_count  = 0;
    int  reg_writes      = 0;
    int  unmapped_writes = 0;
    int  settings_count  = 0;
    int  next_hold       = 300;
    int  stalled_cycles  = 0;
    bit  calm            = 1'b0;

    // directed opening: first sample bypass, extremes, unmapped writes,
    // all-zero bounds, out-of-order bounds, decay-only envelope
    t_script_row script_rows [NUM_ROWS] = '{
        '{ROW_WRITE, REG_TEXTURE_GAIN,  16'hFFFF,      1'b0, 16'h0000},
        '{ROW_WRITE, REG_FILTER_ALPHA,  16'h0000,      1'b0, 16'h0000},
        '{ROW_WRITE, REG_RELEASE_END,   16'hFFFF,      1'b0, 16'h0000},
        '{ROW_WRITE, REG_SUSTAIN_LEVEL, 16'hFFFF,      1'b0, 16'h0000},
        '{ROW_NOISE, REG_TEXTURE_GAIN,  16'd8191,      1'b0, 16'h0000},
        '{ROW_NOISE, REG_TEXTURE_GAIN,  16'(-8192),    1'b0, 16'h0000},
        '{ROW_WRITE, REG_FILTER_ALPHA,  16'hFFFF,      1'b0, 16'h0000},
        '{ROW_WRITE, REG_SPARE_A,       16'hFFFF,      1'b0, 16'h0000},
        '{ROW_WRITE, REG_SPARE_B,       16'h00FF,      1'b0, 16'h0000},
        '{ROW_NOISE, REG_TEXTURE_GAIN,  16'(-8192),    1'b0, 16'h0000},
        '{ROW_NOISE, REG_TEXTURE_GAIN,  16'd1,         1'b0, 16'h0000},
        '{ROW_WRITE, REG_RELEASE_END,   16'h0000,      1'b0, 16'h0000},
        '{ROW_NOISE, REG_TEXTURE_GAIN,  16'd8191,      1'b1, 16'h0000},
        '{ROW_NOISE, REG_TEXTURE_GAIN,  16'(-8192),    1'b1, 16'h0000},
        '{ROW_WRITE, REG_ATTACK_END,    16'hFFFF,      1'b0, 16'h0000},
        '{ROW_NOISE, REG_TEXTURE_GAIN,  16'd5461,      1'b0, 16'h0000},
        '{ROW_NOISE, REG_TEXTURE_GAIN,  16'(-5462),    1'b0, 16'h0000},
        '{ROW_WRITE, REG_ATTACK_END,    16'd10,        1'b0, 16'h0000},
        '{ROW_WRITE, REG_DECAY_END,     16'd5,         1'b0, 16'h0000},
        '{ROW_WRITE, REG_RELEASE_END,   16'd40,        1'b0, 16'h0000},
        '{ROW_WRITE, REG_SUSTAIN_LEVEL, 16'd40000,     1'b0, 16'h0000},
        '{ROW_WRITE, REG_FILTER_ALPHA,  16'd30000,     1'b0, 16'h0000},
        '{ROW_NOISE, REG_TEXTURE_GAIN,  16'(-5000),    1'b0, 16'h0000},
        '{ROW_NOISE, REG_TEXTURE_GAIN,  16'd4999,      1'b0, 16'h0000},
        '{ROW_NOISE, REG_TEXTURE_GAIN,  16'(-1),       1'b0, 16'h0000},
        '{ROW_NOISE, REG_TEXTURE_GAIN,  16'd2,         1'b0, 16'h0000},
        '{ROW_WRITE, REG_ATTACK_END,    16'h0000,      1'b0, 16'h0000},
        '{ROW_WRITE, REG_DECAY_END,     16'd30,        1'b0, 16'h0000},
        '{ROW_WRITE, REG_RELEASE_END,   16'h0000,      1'b0, 16'h0000},
        '{ROW_WRITE, REG_SUSTAIN_LEVEL, 16'h0000,      1'b0, 16'h0000},
        '{ROW_WRITE, REG_TEXTURE_GAIN,  16'h0000,      1'b0, 16'h0000},
        '{ROW_NOISE, REG_TEXTURE_GAIN,  16'd8191,      1'b0, 16'h0000},
        '{ROW_WRITE, REG_TEXTURE_GAIN,  16'd8000,      1'b0, 16'h0000},
        '{ROW_NOISE, REG_TEXTURE_GAIN,  16'(-8192),    1'b0, 16'h0000},
        '{ROW_NOISE, REG_TEXTURE_GAIN,  16'd0,         1'b0, 16'h0000}
    };

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    // fixed-point helpers of the predictor
    function automatic longint shift16_trunc(input longint v);
        if (v < 0)
            return -((-v) >>> 16);
        return v >>> 16;
    endfunction

    function automatic logic [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return 16'(v);
    endfunction

    // floor(k^2 / span^2) in q16
    function automatic longint unsigned square_ratio(input longint unsigned span,
                                                     input longint unsigned k);
        return ((k * k) << 16) / (span * span);
    endfunction

    // adsr level in q16 for a position within the note
    function automatic longint unsigned envelope_level(input longint unsigned pos);
        longint unsigned a_end, d_end, r_end, sus;
        a_end = reg_shadow[REG_ATTACK_END];
        d_end = reg_shadow[REG_DECAY_END];
        r_end = reg_shadow[REG_RELEASE_END];
        sus   = reg_shadow[REG_SUSTAIN_LEVEL];
        if (pos < a_end)
            return 65536 - square_ratio(a_end, a_end - pos);
        if (pos < d_end)
            return sus + (((65536 - sus) * square_ratio(d_end, d_end - (pos - a_end))) >> 16);
        if (pos < r_end)
            return (sus * square_ratio(r_end, r_end - (pos - d_end))) >> 16;
        return 0;
    endfunction

    // next voice sample for one noise word, advancing the note state
    function automatic t_voice_out synth_next_sample(input logic [13:0] noise);
        longint     n, x, acc, gain, alpha;
        t_voice_out y;
        gain  = longint'(reg_shadow[REG_TEXTURE_GAIN]);
        alpha = longint'(reg_shadow[REG_FILTER_ALPHA]);
        n = longint'($signed(noise));
        x = longint'($signed(clamp16(shift16_trunc(gain * n))));
        if (voice_index != 0) begin
            acc = alpha * x + (65536 - alpha) * voice_prev;
            x = longint'($signed(clamp16(shift16_trunc(acc))));
        end
        y.sample = clamp16(shift16_trunc(x * longint'(envelope_level(voice_index))));
        y.last   = (voice_index >= NOTE_LAST_INDEX);
        if (y.last) begin
            voice_index = '0;
            voice_prev  = 0;
        end else begin
            voice_index = voice_index + 16'd1;
            voice_prev  = longint'($signed(y.sample));
        end
        return y;
    endfunction

    // register port, setup then access
    task automatic apb_write(input t_reg_sel sel, input logic [15:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {16'h0000, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        reg_writes++;
        if (sel <= REG_SUSTAIN_LEVEL)
            reg_shadow[sel] = value;
        else
            unmapped_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input t_reg_sel sel, output logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {sel, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // read back every mapped register against the shadow copy
    task automatic check_registers();
        logic [31:0] got;
        for (int k = 0; k <= int'(REG_SUSTAIN_LEVEL); k++) begin
            apb_read(t_reg_sel'(k), got);
            if (got !== {16'h0000, reg_shadow[k]})
                report_mismatch($sformatf("register %0d read %0h, wrote %0h",
                                          k, got, reg_shadow[k]));
        end
    endtask

    // offer one noise word and hold it until taken
    task automatic push_noise(input logic [13:0] noise, input logic fixed,
                              input logic [15:0] want);
        t_voice_out predicted;
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, noise};
        do @(posedge i_clk); while (s_tready !== 1'b1);
        predicted = synth_next_sample(noise);
        if (fixed)
            predicted = '{sample: want, last: 1'b0};
        pending_samples.insert(pending_samples.size(), predicted);
        words_sent++;
    endtask

    task automatic idle_sender(input int cycles);
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // stop offering and wait for every predicted sample to come out
    task automatic drain_results();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // output side: random stalls, two long hold-offs, none at the end
    initial begin
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!calm && samples_seen >= next_hold && next_hold < 1200) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                next_hold += 700;
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 60)) @(negedge i_clk);
            end
        end
    end

    // compare each sample word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            samples_seen++;
            if (pending_samples.size() == 0) begin
                report_mismatch($sformatf("sample %0d with none predicted",
                                          $signed(m_tdata)));
            end else begin
                head_sample = pending_samples.pop_front();
                if (m_tdata !== head_sample.sample)
                    report_mismatch($sformatf("sample %0d, predicted %0d",
                                              $signed(m_tdata),
                                              $signed(head_sample.sample)));
                if (m_tlast !== head_sample.last)
                    report_mismatch($sformatf("note end flag %b, predicted %b",
                                              m_tlast, head_sample.last));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("noise_voice_lowpass_envelope_unit regression: fail");
                $finish;
            end
        end
    end

    // main sequence
    initial begin
        int           base, a_end, d_end, r_end, span, level;
        bit           gappy;
        logic [13:0]  noise;

        reg_shadow[REG_TEXTURE_GAIN]  = 16'h0000;
        reg_shadow[REG_FILTER_ALPHA]  = 16'hFFFF;
        reg_shadow[REG_ATTACK_END]    = 16'h0000;
        reg_shadow[REG_DECAY_END]     = 16'h0000;
        reg_shadow[REG_RELEASE_END]   = 16'h0000;
        reg_shadow[REG_SUSTAIN_LEVEL] = 16'h0000;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values
        check_registers();

        // directed table
        foreach (script_rows[k]) begin
            if (script_rows[k].kind == ROW_WRITE) begin
                drain_results();
                apb_write(script_rows[k].sel, script_rows[k].value);
            end else begin
                if ($urandom_range(0, 2) == 0)
                    idle_sender($urandom_range(1, 13));
                push_noise(script_rows[k].value[13:0], script_rows[k].fixed,
                           script_rows[k].want);
            end
        end

        // random phases, each under its own register setting
        while (words_sent < TOTAL_WORDS) begin
            drain_results();
            base = int'(voice_index);
            case ($urandom_range(0, 7))
                0: begin    // release only
                    a_end = 0;
                    d_end = 0;
                    r_end = base + $urandom_range(1, 150);
                end
                1: begin    // attack over the whole note
                    a_end = 65535;
                    d_end = $urandom_range(0, 65535);
                    r_end = $urandom_range(0, 65535);
                end
                2: begin    // bounds out of order
                    a_end = base + $urandom_range(20, 80);
                    d_end = base + $urandom_range(0, 60);
                    r_end = base + $urandom_range(0, 200);
                end
                3: begin    // long release tail
                    a_end = base + $urandom_range(0, 40);
                    d_end = 0;
                    r_end = 65535;
                end
                default: begin
                    a_end = base + $urandom_range(0, 30);
                    d_end = a_end + $urandom_range(0, 60);
                    r_end = d_end + $urandom_range(0, 120);
                end
            endcase
            apb_write(REG_TEXTURE_GAIN, pick_level());
            apb_write(REG_FILTER_ALPHA, pick_level());
            apb_write(REG_ATTACK_END, 16'(a_end));
            apb_write(REG_DECAY_END, 16'(d_end));
            apb_write(REG_RELEASE_END, 16'(r_end));
            apb_write(REG_SUSTAIN_LEVEL, pick_level());
            if ($urandom_range(0, 3) == 0)
                apb_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
            check_registers();
            settings_count++;

            if (TOTAL_WORDS - words_sent <= CALM_WORDS)
                calm = 1'b1;
            span = calm ? TOTAL_WORDS - words_sent : $urandom_range(40, 150);
            if (span > TOTAL_WORDS - words_sent)
                span = TOTAL_WORDS - words_sent;
            gappy = ($urandom_range(0, 3) != 0);

            repeat (span) begin
                // mostly the nominal noise range, sometimes any 14-bit value
                if ($urandom_range(0, 9) == 0) begin
                    noise = 14'($urandom);
                end else begin
                    level = int'($urandom_range(0, 9999)) - 5000;
                    noise = level[13:0];
                end
                if (gappy && !calm && $urandom_range(0, 2) == 0)
                    idle_sender($urandom_range(1, 13));
                push_noise(noise, 1'b0, 16'h0000);
            end
        end

        // let the last samples out, then watch for strays
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d noise words, %0d random settings, %0d writes (%0d unmapped)",
                 words_sent, settings_count, reg_writes, unmapped_writes);
        $display("compared %0d samples, note position %0d of %0d at the end",
                 samples_seen, voice_index, NOTE_SAMPLES);
        if (mismatch_count == 0)
            $display("noise_voice_lowpass_envelope_unit regression: pass");
        else
            $display("noise_voice_lowpass_envelope_unit regression: fail");
        $finish;
    end

endmodule
